// ----- design/knn2_pkg.sv -----
`default_nettype none
package knn2_pkg;

   // Item kinds
   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   // Register indexes
   localparam logic [3:0] REG_DISTANCE_LIMIT  = 4'd0;
   localparam logic [3:0] REG_NEIGHBOUR_COUNT = 4'd1;

   // One stored point
   typedef struct packed {
      logic               valid;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [7:0]         idx;
   } point_type;

   // Control shared by every cell of the store
   typedef struct packed {
      logic clear;
      logic load;
      logic rotate;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ----- design/knn2_cell.sv -----
`default_nettype none
module knn2_cell (
   input  wire                       clock,
   input  wire                       reset,
   input  wire knn2_pkg::cell_ctrl_type ctrl,
   input  wire knn2_pkg::point_type  new_pt,
   input  wire knn2_pkg::point_type  prev_pt,
   input  wire                       prev_greater,
   input  wire knn2_pkg::point_type  next_pt,
   output knn2_pkg::point_type       pt,
   output logic                      greater
);

   knn2_pkg::point_type pt_ff, pt_in;

   // Stored point lies strictly above the incoming y
   assign greater = pt_ff.valid && (pt_ff.y > new_pt.y);
   assign pt      = pt_ff;

   // Sorted insertion shifts up; rotation passes points toward cell zero
   always_comb begin
      pt_in = pt_ff;
      if (ctrl.clear) begin
         pt_in.valid = 1'b0;
      end else if (ctrl.load) begin
         if (prev_greater) begin
            pt_in = prev_pt;
         end else if (greater || (!pt_ff.valid && prev_pt.valid)) begin
            pt_in       = new_pt;
            pt_in.valid = 1'b1;
         end
      end else if (ctrl.rotate) begin
         pt_in = next_pt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ff.valid <= 1'b0;
      end else begin
         pt_ff.valid <= pt_in.valid;
      end
      pt_ff.x   <= pt_in.x;
      pt_ff.y   <= pt_in.y;
      pt_ff.idx <= pt_in.idx;
   end

endmodule
`default_nettype wire

// ----- design/knn2_sqrt.sv -----
`default_nettype none
module knn2_sqrt (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [33:0] value,
   output logic        done,
   output logic [16:0] root
);

   logic [33:0] v_ff, v_in;
   logic [19:0] rem_ff, rem_in;
   logic [16:0] root_ff, root_in;
   logic [4:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [19:0] rem_sh;
   logic [19:0] trial;

   assign rem_sh = {rem_ff[17:0], v_ff[33:32]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign done   = done_ff;
   assign root   = root_ff;

   // Two radicand bits per cycle, one root bit per cycle while busy
   always_comb begin
      v_in    = v_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = value;
         rem_in  = '0;
         root_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         v_in = {v_ff[31:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[15:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[15:0], 1'b0};
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd16) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
   end

endmodule
`default_nettype wire

// ----- design/k_nearest_neighbour_2d_core.sv -----
// Clear and load items are taken only in idle; a load shifts the sorted store in place.
// A query rotates the cell chain once past the distance unit, then for each result runs
// the bit-serial root plus the output handshake; a query on an empty store gives no result.
// Reset (synchronous, active high) empties the store, sets limit 65535 and k 1.
`default_nettype none
module k_nearest_neighbour_2d_core #(
   parameter int MAX_POINTS     = 256,
   parameter int MAX_NEIGHBOURS = 8
) (
   input  wire         clock,
   input  wire         reset,
   // req_tdata: point_x [15:0], point_y [31:16]
   input  wire  [31:0] req_tdata,
   // req_tuser: kind [1:0]
   input  wire  [1:0]  req_tuser,
   input  wire         req_tvalid,
   output logic        req_tready,
   // rsp_tdata: neighbour_index [7:0], distance [24:8], zero [31:25]
   output logic [31:0] rsp_tdata,
   // rsp_tuser: found [0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [3:0]  csr_index,
   input  wire  [15:0] csr_data
);

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int ROT_W  = $clog2(MAX_POINTS + 2);
   localparam int SIZE_W = $clog2(MAX_NEIGHBOURS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_ROOT = 2'd2;
   localparam logic [1:0] ST_SEND = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [15:0]       limit_ff;
   logic [3:0]        kcount_ff;
   logic [CNT_W-1:0]  total_ff;
   logic [7:0]        load_cnt_ff;
   logic [ROT_W-1:0]  rot_ff, rot_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] sent_ff, sent_in;
   logic signed [15:0] qx_ff, qy_ff;
   logic              go_ff, go_in;

   logic        req_acc, rsp_acc;
   logic [1:0]  kind;
   logic        full;
   logic [31:0] k_eff, size_full;
   logic [33:0] lim2;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign kind       = req_tuser;
   assign full       = (total_ff == CNT_W'(MAX_POINTS));
   assign lim2       = {18'd0, limit_ff} * {18'd0, limit_ff};

   // Result count: k clamped to one..MAX_NEIGHBOURS, then to the stored count
   always_comb begin
      k_eff = {28'd0, kcount_ff};
      if (k_eff == 32'd0) k_eff = 32'd1;
      if (k_eff > 32'(MAX_NEIGHBOURS)) k_eff = 32'(MAX_NEIGHBOURS);
      size_full = (32'(total_ff) < k_eff) ? 32'(total_ff) : k_eff;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= 16'hFFFF;
         kcount_ff <= 4'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            knn2_pkg::REG_DISTANCE_LIMIT:  limit_ff  <= csr_data;
            knn2_pkg::REG_NEIGHBOUR_COUNT: kcount_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Point store: chain of cells
   knn2_pkg::cell_ctrl_type ctrl;
   knn2_pkg::point_type     new_pt;
   knn2_pkg::point_type     cell_pt [MAX_POINTS];
   logic                    cell_gt [MAX_POINTS];

   always_comb begin
      ctrl.clear  = req_acc && (kind == knn2_pkg::KIND_CLEAR);
      ctrl.load   = req_acc && (kind == knn2_pkg::KIND_LOAD) && !full;
      ctrl.rotate = (state_ff == ST_SCAN) && (32'(rot_ff) < 32'(MAX_POINTS));
      new_pt.valid = 1'b1;
      new_pt.x     = req_tdata[15:0];
      new_pt.y     = req_tdata[31:16];
      new_pt.idx   = load_cnt_ff;
   end

   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      localparam int NXT = (i + 1) % MAX_POINTS;
      if (i == 0) begin : g_head
         knn2_cell u_cell (
            .clock(clock), .reset(reset), .ctrl(ctrl), .new_pt(new_pt),
            .prev_pt(new_pt), .prev_greater(1'b0), .next_pt(cell_pt[NXT]),
            .pt(cell_pt[i]), .greater(cell_gt[i])
         );
      end else begin : g_body
         knn2_cell u_cell (
            .clock(clock), .reset(reset), .ctrl(ctrl), .new_pt(new_pt),
            .prev_pt(cell_pt[i-1]), .prev_greater(cell_gt[i-1]),
            .next_pt(cell_pt[NXT]), .pt(cell_pt[i]), .greater(cell_gt[i])
         );
      end
   end

   // Store count and load index
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         load_cnt_ff <= '0;
      end else if (ctrl.clear) begin
         total_ff    <= '0;
         load_cnt_ff <= '0;
      end else if (ctrl.load) begin
         total_ff    <= total_ff + CNT_W'(1);
         load_cnt_ff <= load_cnt_ff + 8'd1;
      end
   end

   // Distance stage: squared offsets from the query of the point at the head of the chain
   logic signed [16:0] dx, dy;
   logic [31:0] sqx_ff, sqy_ff;
   logic        s1_valid_ff, s1_above_ff;
   logic [7:0]  s1_idx_ff;
   logic signed [33:0] sqx_full, sqy_full;

   assign dx       = {cell_pt[0].x[15], cell_pt[0].x} - {qx_ff[15], qx_ff};
   assign dy       = {cell_pt[0].y[15], cell_pt[0].y} - {qy_ff[15], qy_ff};
   assign sqx_full = dx * dx;
   assign sqy_full = dy * dy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctrl.rotate && cell_pt[0].valid;
      end
      sqx_ff      <= sqx_full[31:0];
      sqy_ff      <= sqy_full[31:0];
      s1_above_ff <= cell_pt[0].y > qy_ff;
      s1_idx_ff   <= cell_pt[0].idx;
   end

   // Best list: sorted insertion; equal distance wins only over a point at or below query y
   logic [33:0] best_d2_ff  [MAX_NEIGHBOURS];
   logic [7:0]  best_idx_ff [MAX_NEIGHBOURS];
   logic        best_fnd_ff [MAX_NEIGHBOURS];
   logic        best_abv_ff [MAX_NEIGHBOURS];
   logic        better      [MAX_NEIGHBOURS];
   logic [33:0] d2;

   assign d2 = {2'b00, sqx_ff} + {2'b00, sqy_ff};

   always_comb begin
      for (int j = 0; j < MAX_NEIGHBOURS; j++) begin
         better[j] = (d2 < best_d2_ff[j]) || ((d2 == best_d2_ff[j]) && !best_abv_ff[j]);
      end
   end

   logic list_init, list_shift;
   assign list_init  = req_acc && (kind == knn2_pkg::KIND_QUERY);
   assign list_shift = (state_ff == ST_SEND) && rsp_acc;

   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_NEIGHBOURS; j++) begin
         if (list_init) begin
            best_d2_ff[j]  <= lim2;
            best_idx_ff[j] <= '0;
            best_fnd_ff[j] <= 1'b0;
            best_abv_ff[j] <= 1'b1;
         end else if (list_shift) begin
            if (j < MAX_NEIGHBOURS - 1) begin
               best_d2_ff[j]  <= best_d2_ff[(j+1)%MAX_NEIGHBOURS];
               best_idx_ff[j] <= best_idx_ff[(j+1)%MAX_NEIGHBOURS];
               best_fnd_ff[j] <= best_fnd_ff[(j+1)%MAX_NEIGHBOURS];
               best_abv_ff[j] <= best_abv_ff[(j+1)%MAX_NEIGHBOURS];
            end
         end else if (s1_valid_ff) begin
            if (j > 0 && better[(j+MAX_NEIGHBOURS-1)%MAX_NEIGHBOURS]) begin
               best_d2_ff[j]  <= best_d2_ff[(j+MAX_NEIGHBOURS-1)%MAX_NEIGHBOURS];
               best_idx_ff[j] <= best_idx_ff[(j+MAX_NEIGHBOURS-1)%MAX_NEIGHBOURS];
               best_fnd_ff[j] <= best_fnd_ff[(j+MAX_NEIGHBOURS-1)%MAX_NEIGHBOURS];
               best_abv_ff[j] <= best_abv_ff[(j+MAX_NEIGHBOURS-1)%MAX_NEIGHBOURS];
            end else if (better[j]) begin
               best_d2_ff[j]  <= d2;
               best_idx_ff[j] <= s1_idx_ff;
               best_fnd_ff[j] <= 1'b1;
               best_abv_ff[j] <= s1_above_ff;
            end
         end
      end
   end

   // Root unit on the list head
   logic        sq_start, sq_done;
   logic [16:0] sq_root;

   assign sq_start = (state_ff == ST_ROOT) && !go_ff;

   knn2_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start),
      .value(best_d2_ff[0]), .done(sq_done), .root(sq_root)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      rot_in   = rot_ff;
      size_in  = size_ff;
      sent_in  = sent_ff;
      go_in    = go_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (list_init && size_full != 32'd0) begin
               state_in = ST_SCAN;
               rot_in   = '0;
               size_in  = size_full[SIZE_W-1:0];
               sent_in  = '0;
            end
         end
         ST_SCAN: begin
            rot_in = rot_ff + ROT_W'(1);
            if (32'(rot_ff) == 32'(MAX_POINTS)) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (sq_start) go_in = 1'b1;
            if (sq_done) begin
               go_in    = 1'b0;
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_acc) begin
               sent_in  = sent_ff + SIZE_W'(1);
               state_in = (sent_ff == size_ff - SIZE_W'(1)) ? ST_IDLE : ST_ROOT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         go_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
      end
      rot_ff  <= rot_in;
      size_ff <= size_in;
      sent_ff <= sent_in;
      if (list_init) begin
         qx_ff <= req_tdata[15:0];
         qy_ff <= req_tdata[31:16];
      end
   end

   // Output register
   logic [7:0]  o_idx_ff;
   logic [16:0] o_dist_ff;
   logic        o_fnd_ff, o_last_ff;

   always_ff @(posedge clock) begin
      if (sq_done) begin
         o_idx_ff  <= best_fnd_ff[0] ? best_idx_ff[0] : 8'd0;
         o_fnd_ff  <= best_fnd_ff[0];
         o_dist_ff <= sq_root;
         o_last_ff <= (sent_ff == size_ff - SIZE_W'(1));
      end
   end

   assign rsp_tvalid = (state_ff == ST_SEND);
   assign rsp_tdata  = {7'd0, o_dist_ff, o_idx_ff};
   assign rsp_tuser  = o_fnd_ff;
   assign rsp_tlast  = o_last_ff;

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) <= 32'(MAX_POINTS))
      else $error("point count beyond store depth");
   a_scan_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !rsp_tvalid && !sq_done)
      else $error("result activity during scan");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_tlast) |=> (state_ff == ST_IDLE))
      else $error("query not finished after last result");
`endif

endmodule
`default_nettype wire
